FILE: rtl/dbm_pkg.sv
package dbm_pkg;

    localparam int DEPTH_W   = 16;
    localparam int INDEX_W   = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_MASK  = 2'd0,
        MODE_COPY  = 2'd1,
        MODE_MIN   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR   = 3'd0,
        CFG_FAR    = 3'd1,
        CFG_CLEAR  = 3'd2,
        CFG_MARGIN = 3'd3,
        CFG_ENABLE = 3'd4
    } t_cfg_idx;

    // write side of the background store
    typedef struct packed {
        logic               en;
        logic [DEPTH_W-1:0] data;
    } t_store_wr;

endpackage

FILE: rtl/dbm_store.sv
module dbm_store
    import dbm_pkg::*;
#(
    parameter int PIXELS = 307200,
    parameter int AW     = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    input  t_store_wr          i_wr,
    input  logic [AW-1:0]      i_wr_addr,
    output logic [DEPTH_W-1:0] o_rd_data
);

    logic [DEPTH_W-1:0] r_mem [PIXELS];
    logic [DEPTH_W-1:0] r_rd_data;
    logic [AW-1:0]      r_rd_addr;
    logic               r_fwd_valid;
    logic [AW-1:0]      r_fwd_addr;
    logic [DEPTH_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // remember the last write; a read issued on the same edge gets that write's data, not the old entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr.en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;

endmodule

FILE: rtl/depth_background_mask.sv
// The input transaction and the store read share the edge into stage 1; the result is
// registered in the output stage, and stage 1 holds while the output is stalled.
// Throughput: one pixel per cycle while the output is ready; the store does at most one
// read and one write per cycle, with the last write forwarded to the following pixel.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults;
// the background store is not cleared and must be copied or cleared before it is read.
module depth_background_mask
    import dbm_pkg::*;
#(
    parameter int PIXELS = 307200
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DEPTH_W-1:0]    i_depth,
    input  logic [INDEX_W-1:0]    i_pixel_index,
    input  logic [1:0]            i_mode,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_mask_on,
    output logic                  o_background_hit
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [20:0] PIX_LIMIT = 21'(PIXELS);

    logic [DEPTH_W-1:0] r_near;
    logic [DEPTH_W-1:0] r_far;
    logic [DEPTH_W-1:0] r_clear;
    logic [DEPTH_W-1:0] r_margin;
    logic               r_bg_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near      <= '0;
            r_far       <= '1;
            r_clear     <= '1;
            r_margin    <= '0;
            r_bg_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEAR:   r_near      <= i_cfg_data;
                CFG_FAR:    r_far       <= i_cfg_data;
                CFG_CLEAR:  r_clear     <= i_cfg_data;
                CFG_MARGIN: r_margin    <= i_cfg_data;
                CFG_ENABLE: r_bg_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic               in_accept;
    logic               in_range;
    logic [AW-1:0]      in_addr;
    logic               s1_adv;
    logic               r_s1_valid;
    logic [DEPTH_W-1:0] r_s1_depth;
    logic [AW-1:0]      r_s1_addr;
    logic               r_s1_in_range;
    t_mode              r_s1_mode;
    logic               r_out_valid;
    logic               r_mask_on;
    logic               r_bg_hit;
    logic               n_mask_on;
    logic               n_bg_hit;
    logic [DEPTH_W-1:0] bg_data;
    logic signed [16:0] bg_diff;
    t_store_wr          store_wr;

    assign in_range   = {2'b00, i_pixel_index} < PIX_LIMIT;
    assign in_addr    = AW'(i_pixel_index);
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_depth    <= i_depth;
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_mode     <= t_mode'(i_mode);
        end
    end

    dbm_store #(
        .PIXELS (PIXELS),
        .AW     (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_range),
        .i_rd_addr (in_addr),
        .i_wr      (store_wr),
        .i_wr_addr (r_s1_addr),
        .o_rd_data (bg_data)
    );

    always_comb begin
        bg_diff   = $signed({1'b0, bg_data}) - $signed({1'b0, r_margin});
        n_bg_hit  = r_s1_in_range && r_bg_enable && (bg_diff <= $signed({1'b0, r_s1_depth}));
        n_mask_on = !n_bg_hit && (r_s1_depth > r_near) && (r_s1_depth < r_far);
    end

    always_comb begin
        store_wr.en   = 1'b0;
        store_wr.data = r_s1_depth;
        case (r_s1_mode)
            MODE_COPY: begin
                store_wr.en = 1'b1;
            end
            MODE_MIN: begin
                store_wr.en = (r_s1_depth != '0) && (bg_data > r_s1_depth);
            end
            MODE_CLEAR: begin
                store_wr.en   = 1'b1;
                store_wr.data = r_clear;
            end
            default: ;
        endcase
        // drop the update unless the pixel leaves stage 1 with a valid index
        store_wr.en = store_wr.en && s1_adv && r_s1_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mask_on <= n_mask_on;
            r_bg_hit  <= n_bg_hit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mask_on        = r_mask_on;
    assign o_background_hit = r_bg_hit;

    a_hit_clears_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bg_hit |-> !r_mask_on)
        else $error("background hit with mask set");

    a_hit_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_bg_hit |-> r_bg_enable)
        else $error("background hit while suppression disabled");

    a_write_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_wr.en |-> s1_adv && r_s1_in_range)
        else $error("store written without a pixel leaving stage 1");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

endmodule
